[rtl/bptc_pkg.sv]
// Shared types and constants for the barometer compensation pipeline.
package bptc_pkg;

    localparam logic [19:0] RESET_PATTERN = 20'h80000;
    localparam logic [20:0] PRESS_FULL    = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE   = 12'd3125;
    localparam logic signed [32:0] TFINE_OFFSET = 33'sd128000;
    localparam int unsigned P1_BIAS_SHIFT = 47;
    localparam int unsigned DIVISOR_SHIFT = 33;
    localparam int unsigned DIV_BITS      = 64;

    localparam logic [1:0] REG_TEMP = 2'd0;
    localparam logic [1:0] REG_PA   = 2'd1;
    localparam logic [1:0] REG_PB   = 2'd2;
    localparam logic [1:0] REG_P9   = 2'd3;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_SKIP  = 2'd1,
        ST_FAULT = 2'd2
    } t_status;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coeffs;

    typedef struct packed {
        logic signed [31:0] temp;
        logic               skip;
        logic               fault;
    } t_side;

    typedef struct packed {
        logic [31:0] press;
        logic [31:0] temp;
        t_status     status;
    } t_out;

endpackage

[rtl/bptc_cfg.sv]
// Calibration register file behind the APB-style configuration port.
module bptc_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    output bptc_pkg::t_coeffs     o_coeffs
);

    logic [47:0] r_temp;
    logic [63:0] r_pa;
    logic [63:0] r_pb;
    logic [15:0] r_p9;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_p9   <= '0;
        end else if (w_wr) begin
            case (paddr[4:3])
                bptc_pkg::REG_TEMP: r_temp <= pwdata[47:0];
                bptc_pkg::REG_PA:   r_pa   <= pwdata;
                bptc_pkg::REG_PB:   r_pb   <= pwdata;
                bptc_pkg::REG_P9:   r_p9   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            bptc_pkg::REG_TEMP: prdata = {16'd0, r_temp};
            bptc_pkg::REG_PA:   prdata = r_pa;
            bptc_pkg::REG_PB:   prdata = r_pb;
            bptc_pkg::REG_P9:   prdata = {48'd0, r_p9};
            default:            prdata = '0;
        endcase
    end

    assign o_coeffs.t1 = r_temp[15:0];
    assign o_coeffs.t2 = r_temp[31:16];
    assign o_coeffs.t3 = r_temp[47:32];
    assign o_coeffs.p1 = r_pa[15:0];
    assign o_coeffs.p2 = r_pa[31:16];
    assign o_coeffs.p3 = r_pa[47:32];
    assign o_coeffs.p4 = r_pa[63:48];
    assign o_coeffs.p5 = r_pb[15:0];
    assign o_coeffs.p6 = r_pb[31:16];
    assign o_coeffs.p7 = r_pb[47:32];
    assign o_coeffs.p8 = r_pb[63:48];
    assign o_coeffs.p9 = r_p9;

endmodule

[rtl/bptc_front.sv]
// Temperature compensation and pressure numerator/divisor terms, ten stages.
module bptc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [19:0]           i_adc_p,
    input  logic [19:0]           i_adc_t,
    input  bptc_pkg::t_coeffs     i_coeffs,
    output logic                  o_valid,
    output logic [63:0]           o_mag,
    output logic [30:0]           o_md,
    output logic                  o_neg,
    output bptc_pkg::t_side       o_side
);

    // Stage 1: differences and first products.
    logic signed [17:0] w_a;
    logic signed [16:0] w_d;
    logic signed [33:0] n_s1_m1;
    logic signed [33:0] n_s1_dd;
    logic               n_s1_skip;
    logic               r_s1_v;
    logic [31:0]        r_s1_m1;
    logic [31:0]        r_s1_dd;
    logic [19:0]        r_s1_adc_p;
    logic               r_s1_skip;

    assign w_a       = $signed({1'b0, i_adc_t[19:3]}) - $signed({1'b0, i_coeffs.t1, 1'b0});
    assign w_d       = $signed({1'b0, i_adc_t[19:4]}) - $signed({1'b0, i_coeffs.t1});
    assign n_s1_m1   = w_a * i_coeffs.t2;
    assign n_s1_dd   = w_d * w_d;
    assign n_s1_skip = (i_adc_p == bptc_pkg::RESET_PATTERN) ||
                       (i_adc_t == bptc_pkg::RESET_PATTERN);

    // Stage 2
    logic signed [31:0] n_s2_v1t;
    logic signed [31:0] w_s2_dds;
    logic signed [47:0] n_s2_m2;
    logic               r_s2_v;
    logic signed [31:0] r_s2_v1t;
    logic [31:0]        r_s2_m2;
    logic [19:0]        r_s2_adc_p;
    logic               r_s2_skip;

    assign n_s2_v1t = $signed(r_s1_m1) >>> 11;
    assign w_s2_dds = $signed(r_s1_dd) >>> 12;
    assign n_s2_m2  = w_s2_dds * i_coeffs.t3;

    // Stage 3: fine temperature.
    logic signed [31:0] w_s3_v2t;
    logic signed [31:0] n_s3_tf;
    logic               r_s3_v;
    logic signed [31:0] r_s3_tf;
    logic [19:0]        r_s3_adc_p;
    logic               r_s3_skip;

    assign w_s3_v2t = $signed(r_s2_m2) >>> 14;
    assign n_s3_tf  = r_s2_v1t + w_s3_v2t;

    // Stage 4: temperature result and pressure offset term.
    logic [31:0]        w_s4_t5;
    logic signed [31:0] n_s4_temp;
    logic signed [32:0] w_s4_tfe;
    logic signed [32:0] n_s4_x;
    logic               r_s4_v;
    logic signed [32:0] r_s4_x;
    logic [19:0]        r_s4_adc_p;
    bptc_pkg::t_side    r_s4_side;

    assign w_s4_t5   = (r_s3_tf << 2) + r_s3_tf + 32'd128;
    assign n_s4_temp = $signed(w_s4_t5) >>> 8;
    assign w_s4_tfe  = r_s3_tf;
    assign n_s4_x    = w_s4_tfe - bptc_pkg::TFINE_OFFSET;

    // Stage 5: square and linear products of the offset term.
    logic signed [65:0] n_s5_xx;
    logic signed [48:0] n_s5_xp5;
    logic signed [48:0] n_s5_xp2;
    logic               r_s5_v;
    logic [63:0]        r_s5_xx;
    logic signed [48:0] r_s5_xp5;
    logic signed [48:0] r_s5_xp2;
    logic [19:0]        r_s5_adc_p;
    bptc_pkg::t_side    r_s5_side;

    assign n_s5_xx  = r_s4_x * r_s4_x;
    assign n_s5_xp5 = r_s4_x * i_coeffs.p5;
    assign n_s5_xp2 = r_s4_x * i_coeffs.p2;

    // Stage 6
    logic signed [79:0] n_s6_ya;
    logic signed [79:0] n_s6_xxp3;
    logic signed [63:0] w_s6_xp5e;
    logic signed [63:0] w_s6_xp2e;
    logic signed [63:0] w_s6_p4e;
    logic [63:0]        n_s6_yb;
    logic [63:0]        n_s6_xb;
    logic               r_s6_v;
    logic [63:0]        r_s6_ya;
    logic [63:0]        r_s6_xxp3;
    logic [63:0]        r_s6_yb;
    logic [63:0]        r_s6_xb;
    logic [19:0]        r_s6_adc_p;
    bptc_pkg::t_side    r_s6_side;

    assign n_s6_ya   = $signed(r_s5_xx) * i_coeffs.p6;
    assign n_s6_xxp3 = $signed(r_s5_xx) * i_coeffs.p3;
    assign w_s6_xp5e = r_s5_xp5;
    assign w_s6_xp2e = r_s5_xp2;
    assign w_s6_p4e  = i_coeffs.p4;
    assign n_s6_yb   = (w_s6_xp5e << 17) + (w_s6_p4e << 35);
    assign n_s6_xb   = w_s6_xp2e << 12;

    // Stage 7
    logic signed [63:0] w_s7_sh;
    logic [63:0]        n_s7_y;
    logic [63:0]        n_s7_x2;
    logic               r_s7_v;
    logic [63:0]        r_s7_y;
    logic [63:0]        r_s7_x2;
    logic [19:0]        r_s7_adc_p;
    bptc_pkg::t_side    r_s7_side;

    assign w_s7_sh = $signed(r_s6_xxp3) >>> 8;
    assign n_s7_y  = r_s6_ya + r_s6_yb;
    assign n_s7_x2 = w_s7_sh + r_s6_xb;

    // Stage 8
    logic [20:0]        w_s8_pf;
    logic [63:0]        w_s8_pfe;
    logic [63:0]        n_s8_t;
    logic [63:0]        n_s8_n0;
    logic               r_s8_v;
    logic [63:0]        r_s8_t;
    logic [63:0]        r_s8_n0;
    bptc_pkg::t_side    r_s8_side;

    assign w_s8_pf  = bptc_pkg::PRESS_FULL - {1'b0, r_s7_adc_p};
    assign w_s8_pfe = {43'd0, w_s8_pf};
    assign n_s8_t   = (64'd1 << bptc_pkg::P1_BIAS_SHIFT) + r_s7_x2;
    assign n_s8_n0  = (w_s8_pfe << 31) - r_s7_y;

    // Stage 9: divisor and scaled numerator.
    logic signed [80:0] w_s9_prod;
    logic [30:0]        n_s9_dv;
    logic [75:0]        n_s9_num;
    logic               r_s9_v;
    logic [30:0]        r_s9_dv;
    logic [63:0]        r_s9_num;
    bptc_pkg::t_side    r_s9_side;

    assign w_s9_prod = $signed(r_s8_t) * $signed({1'b0, i_coeffs.p1});
    assign n_s9_dv   = w_s9_prod[63:bptc_pkg::DIVISOR_SHIFT];
    assign n_s9_num  = r_s8_n0 * bptc_pkg::PRESS_SCALE;

    // Stage 10: magnitudes for the unsigned divider.
    logic               r_s10_v;
    logic [63:0]        r_s10_mag;
    logic [30:0]        r_s10_md;
    logic               r_s10_neg;
    bptc_pkg::t_side    r_s10_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_s9_v  <= 1'b0;
            r_s10_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_s6_v  <= r_s5_v;
            r_s7_v  <= r_s6_v;
            r_s8_v  <= r_s7_v;
            r_s9_v  <= r_s8_v;
            r_s10_v <= r_s9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_m1    <= n_s1_m1[31:0];
            r_s1_dd    <= n_s1_dd[31:0];
            r_s1_adc_p <= i_adc_p;
            r_s1_skip  <= n_s1_skip;

            r_s2_v1t   <= n_s2_v1t;
            r_s2_m2    <= n_s2_m2[31:0];
            r_s2_adc_p <= r_s1_adc_p;
            r_s2_skip  <= r_s1_skip;

            r_s3_tf    <= n_s3_tf;
            r_s3_adc_p <= r_s2_adc_p;
            r_s3_skip  <= r_s2_skip;

            r_s4_x          <= n_s4_x;
            r_s4_adc_p      <= r_s3_adc_p;
            r_s4_side.temp  <= n_s4_temp;
            r_s4_side.skip  <= r_s3_skip;
            r_s4_side.fault <= 1'b0;

            r_s5_xx    <= n_s5_xx[63:0];
            r_s5_xp5   <= n_s5_xp5;
            r_s5_xp2   <= n_s5_xp2;
            r_s5_adc_p <= r_s4_adc_p;
            r_s5_side  <= r_s4_side;

            r_s6_ya    <= n_s6_ya[63:0];
            r_s6_xxp3  <= n_s6_xxp3[63:0];
            r_s6_yb    <= n_s6_yb;
            r_s6_xb    <= n_s6_xb;
            r_s6_adc_p <= r_s5_adc_p;
            r_s6_side  <= r_s5_side;

            r_s7_y     <= n_s7_y;
            r_s7_x2    <= n_s7_x2;
            r_s7_adc_p <= r_s6_adc_p;
            r_s7_side  <= r_s6_side;

            r_s8_t     <= n_s8_t;
            r_s8_n0    <= n_s8_n0;
            r_s8_side  <= r_s7_side;

            r_s9_dv          <= n_s9_dv;
            r_s9_num         <= n_s9_num[63:0];
            r_s9_side.temp   <= r_s8_side.temp;
            r_s9_side.skip   <= r_s8_side.skip;
            r_s9_side.fault  <= (n_s9_dv == 31'd0);

            r_s10_mag  <= r_s9_num[63] ? (64'd0 - r_s9_num) : r_s9_num;
            r_s10_md   <= r_s9_dv[30] ? (31'd0 - r_s9_dv) : r_s9_dv;
            r_s10_neg  <= r_s9_num[63] ^ r_s9_dv[30];
            r_s10_side <= r_s9_side;
        end
    end

    assign o_valid = r_s10_v;
    assign o_mag   = r_s10_mag;
    assign o_md    = r_s10_md;
    assign o_neg   = r_s10_neg;
    assign o_side  = r_s10_side;

endmodule

[rtl/bptc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module bptc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [63:0]           i_mag,
    input  logic [30:0]           i_md,
    input  logic                  i_neg,
    input  bptc_pkg::t_side       i_side,
    output logic                  o_valid,
    output logic [63:0]           o_quot,
    output logic                  o_neg,
    output bptc_pkg::t_side       o_side
);

    localparam int unsigned N = bptc_pkg::DIV_BITS;

    // The dividend shifts out of the top of dq while quotient bits enter at the bottom.
    logic                  r_v    [N];
    logic [31:0]           r_rem  [N];
    logic [63:0]           r_dq   [N];
    logic [30:0]           r_md   [N];
    logic                  r_neg  [N];
    bptc_pkg::t_side       r_side [N];

    logic                  w_v    [N+1];
    logic [31:0]           w_rem  [N+1];
    logic [63:0]           w_dq   [N+1];
    logic [30:0]           w_md   [N+1];
    logic                  w_neg  [N+1];
    bptc_pkg::t_side       w_side [N+1];

    logic [31:0]           w_sh   [N];
    logic [32:0]           w_diff [N];
    logic [31:0]           n_rem  [N];
    logic [63:0]           n_dq   [N];

    always_comb begin
        w_v[0]    = i_valid;
        w_rem[0]  = '0;
        w_dq[0]   = i_mag;
        w_md[0]   = i_md;
        w_neg[0]  = i_neg;
        w_side[0] = i_side;
        for (int k = 0; k < N; k++) begin
            w_v[k+1]    = r_v[k];
            w_rem[k+1]  = r_rem[k];
            w_dq[k+1]   = r_dq[k];
            w_md[k+1]   = r_md[k];
            w_neg[k+1]  = r_neg[k];
            w_side[k+1] = r_side[k];
        end
        for (int k = 0; k < N; k++) begin
            w_sh[k]   = {w_rem[k][30:0], w_dq[k][63]};
            w_diff[k] = {1'b0, w_sh[k]} - {2'b00, w_md[k]};
            n_rem[k]  = w_diff[k][32] ? w_sh[k] : w_diff[k][31:0];
            n_dq[k]   = {w_dq[k][62:0], ~w_diff[k][32]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_v[k] <= w_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k]  <= n_rem[k];
                r_dq[k]   <= n_dq[k];
                r_md[k]   <= w_md[k];
                r_neg[k]  <= w_neg[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = w_v[N];
    assign o_quot  = w_dq[N];
    assign o_neg   = w_neg[N];
    assign o_side  = w_side[N];

endmodule

[rtl/bptc_back.sv]
// Pressure refinement after the divide: square term, linear term and final scaling.
module bptc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [63:0]           i_quot,
    input  logic                  i_neg,
    input  bptc_pkg::t_side       i_side,
    input  bptc_pkg::t_coeffs     i_coeffs,
    output logic                  o_valid,
    output bptc_pkg::t_out        o_result
);

    // Stage 1: apply the quotient sign.
    logic               r_b1_v;
    logic [63:0]        r_b1_p;
    bptc_pkg::t_side    r_b1_side;

    // Stage 2: split q = p >>> 13 into high and low halves for the square.
    logic signed [63:0] w_b2_q13;
    logic [25:0]        w_b2_lo;
    logic signed [24:0] w_b2_hi;
    logic [51:0]        n_b2_ll;
    logic signed [51:0] n_b2_hl;
    logic signed [49:0] n_b2_hh;
    logic signed [79:0] n_b2_p8p;
    logic               r_b2_v;
    logic [51:0]        r_b2_ll;
    logic signed [51:0] r_b2_hl;
    logic signed [49:0] r_b2_hh;
    logic [63:0]        r_b2_p8p;
    logic [63:0]        r_b2_p;
    bptc_pkg::t_side    r_b2_side;

    assign w_b2_q13 = $signed(r_b1_p) >>> 13;
    assign w_b2_lo  = w_b2_q13[25:0];
    assign w_b2_hi  = w_b2_q13[50:26];
    assign n_b2_ll  = w_b2_lo * w_b2_lo;
    assign n_b2_hl  = w_b2_hi * $signed({1'b0, w_b2_lo});
    assign n_b2_hh  = w_b2_hi * w_b2_hi;
    assign n_b2_p8p = $signed(r_b1_p) * i_coeffs.p8;

    // Stage 3: recombine the square, modulo 2^64.
    logic [63:0]        w_b3_lle;
    logic signed [63:0] w_b3_hle;
    logic signed [63:0] w_b3_hhe;
    logic [63:0]        n_b3_qq;
    logic               r_b3_v;
    logic [63:0]        r_b3_qq;
    logic [63:0]        r_b3_p8p;
    logic [63:0]        r_b3_p;
    bptc_pkg::t_side    r_b3_side;

    assign w_b3_lle = {12'd0, r_b2_ll};
    assign w_b3_hle = r_b2_hl;
    assign w_b3_hhe = r_b2_hh;
    assign n_b3_qq  = w_b3_lle + (w_b3_hle << 27) + (w_b3_hhe << 52);

    // Stage 4
    logic signed [79:0] n_b4_pq;
    logic               r_b4_v;
    logic [63:0]        r_b4_pq;
    logic [63:0]        r_b4_p8p;
    logic [63:0]        r_b4_p;
    bptc_pkg::t_side    r_b4_side;

    assign n_b4_pq = $signed(r_b3_qq) * i_coeffs.p9;

    // Stage 5: only the low 40 bits of the sum reach the 32-bit result.
    logic signed [63:0] w_b5_xs;
    logic signed [63:0] w_b5_ys;
    logic [63:0]        w_b5_sum;
    logic signed [31:0] w_b5_p7e;
    logic [31:0]        w_b5_press;
    bptc_pkg::t_out     n_b5_out;
    logic               r_b5_v;
    bptc_pkg::t_out     r_b5_out;

    assign w_b5_xs    = $signed(r_b4_pq) >>> 25;
    assign w_b5_ys    = $signed(r_b4_p8p) >>> 19;
    assign w_b5_sum   = r_b4_p + w_b5_xs + w_b5_ys;
    assign w_b5_p7e   = i_coeffs.p7;
    assign w_b5_press = w_b5_sum[39:8] + (w_b5_p7e << 4);

    always_comb begin
        if (r_b4_side.skip) begin
            n_b5_out.temp   = '0;
            n_b5_out.press  = '0;
            n_b5_out.status = bptc_pkg::ST_SKIP;
        end else if (r_b4_side.fault) begin
            n_b5_out.temp   = r_b4_side.temp;
            n_b5_out.press  = '0;
            n_b5_out.status = bptc_pkg::ST_FAULT;
        end else begin
            n_b5_out.temp   = r_b4_side.temp;
            n_b5_out.press  = w_b5_press;
            n_b5_out.status = bptc_pkg::ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_b4_v <= 1'b0;
            r_b5_v <= 1'b0;
        end else if (i_en) begin
            r_b1_v <= i_valid;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_b4_v <= r_b3_v;
            r_b5_v <= r_b4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_p    <= i_neg ? (64'd0 - i_quot) : i_quot;
            r_b1_side <= i_side;

            r_b2_ll   <= n_b2_ll;
            r_b2_hl   <= n_b2_hl;
            r_b2_hh   <= n_b2_hh;
            r_b2_p8p  <= n_b2_p8p[63:0];
            r_b2_p    <= r_b1_p;
            r_b2_side <= r_b1_side;

            r_b3_qq   <= n_b3_qq;
            r_b3_p8p  <= r_b2_p8p;
            r_b3_p    <= r_b2_p;
            r_b3_side <= r_b2_side;

            r_b4_pq   <= n_b4_pq[63:0];
            r_b4_p8p  <= r_b3_p8p;
            r_b4_p    <= r_b3_p;
            r_b4_side <= r_b3_side;

            r_b5_out  <= n_b5_out;
        end
    end

    assign o_valid  = r_b5_v;
    assign o_result = r_b5_out;

endmodule

[rtl/baro_pressure_temp_compensation.sv]
// Top level of the barometer pressure and temperature compensation pipeline.
//
// Each request carries one raw 20-bit pressure reading and one raw 20-bit
// temperature reading and produces exactly one result: the temperature in
// hundredths of a degree Celsius, the pressure in pascals times 256, and a
// status code (valid, skipped because a raw value holds the reset pattern,
// or pressure fault because the divisor term is zero). The block accepts a
// new request every cycle while the output buffer has room. A request goes
// through a 10-stage front end, the 64-stage divider that resolves one
// quotient bit per stage and a 5-stage back end, then into the output
// buffer. All stages advance together whenever the two-entry output buffer
// has room, so a result may wait at the output while new requests keep
// entering; requests are held back only once both buffer entries are
// occupied. Calibration lives in four registers at byte addresses 0, 8,
// 16 and 24 of the 64-bit configuration port and must only be changed while
// no request is in flight.
module baro_pressure_temp_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [19:0] raw_pressure, [39:20] raw_temperature
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] temp_centi_deg, [63:32] pressure_q24_8
    output logic [1:0]  o_m_tuser,   // [1:0] status
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    bptc_pkg::t_coeffs w_coeffs;

    logic              w_en;
    logic              w_f_valid;
    logic [63:0]       w_f_mag;
    logic [30:0]       w_f_md;
    logic              w_f_neg;
    bptc_pkg::t_side   w_f_side;
    logic              w_d_valid;
    logic [63:0]       w_d_quot;
    logic              w_d_neg;
    bptc_pkg::t_side   w_d_side;
    logic              w_b_valid;
    bptc_pkg::t_out    w_b_result;

    // Output buffer: entry 0 is the head.
    bptc_pkg::t_out    r_buf [2];
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;

    bptc_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_coeffs (w_coeffs)
    );

    // The whole pipeline moves whenever the buffer can take what leaves it.
    assign w_en       = (r_cnt != 2'd2);
    assign o_s_tready = w_en;

    bptc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_s_tvalid),
        .i_adc_p  (i_s_tdata[19:0]),
        .i_adc_t  (i_s_tdata[39:20]),
        .i_coeffs (w_coeffs),
        .o_valid  (w_f_valid),
        .o_mag    (w_f_mag),
        .o_md     (w_f_md),
        .o_neg    (w_f_neg),
        .o_side   (w_f_side)
    );

    bptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_mag   (w_f_mag),
        .i_md    (w_f_md),
        .i_neg   (w_f_neg),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .o_quot  (w_d_quot),
        .o_neg   (w_d_neg),
        .o_side  (w_d_side)
    );

    bptc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_d_valid),
        .i_quot   (w_d_quot),
        .i_neg    (w_d_neg),
        .i_side   (w_d_side),
        .i_coeffs (w_coeffs),
        .o_valid  (w_b_valid),
        .o_result (w_b_result)
    );

    // A result leaves the last pipeline stage on the same edge that advances the pipeline.
    assign w_push = w_en && w_b_valid;
    assign w_pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_buf[0] <= (w_push && r_cnt == 2'd1) ? w_b_result : r_buf[1];
            if (w_push && r_cnt == 2'd2) begin
                r_buf[1] <= w_b_result;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_buf[0] <= w_b_result;
            end else begin
                r_buf[1] <= w_b_result;
            end
        end
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = {r_buf[0].press, r_buf[0].temp};
    assign o_m_tuser  = r_buf[0].status;

endmodule

[test/baro_pressure_temp_compensation_chk.sv]
// Checker for the barometer compensation block: tracks calibration writes, predicts results, compares.
module baro_pressure_temp_compensation_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Calibration as the block holds it, captured from the bus.
    logic [47:0] cal_temp;
    logic [63:0] cal_pa;
    logic [63:0] cal_pb;
    logic [15:0] cal_p9;

    bptc_pkg::t_out readings_due[$];

    function automatic logic signed [63:0] widen16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Signed division truncating toward zero, done on magnitudes.
    function automatic logic signed [63:0] div_trunc(input logic signed [63:0] n,
                                                     input logic signed [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q  = mn / md;
        return (n[63] ^ d[63]) ? -q : q;
    endfunction

    function automatic bptc_pkg::t_out compensate(input logic [19:0] adc_p,
                                                  input logic [19:0] adc_t);
        bptc_pkg::t_out r;
        logic signed [31:0] t1, t2, t3, a, d, m, v1t, v2t, tf;
        logic signed [63:0] x, y, p, q, dv, num;
        r.status = bptc_pkg::ST_VALID;
        r.temp   = '0;
        r.press  = '0;
        if (adc_p == bptc_pkg::RESET_PATTERN || adc_t == bptc_pkg::RESET_PATTERN) begin
            r.status = bptc_pkg::ST_SKIP;
            return r;
        end
        t1  = {16'b0, cal_temp[15:0]};
        t2  = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3  = {{16{cal_temp[47]}}, cal_temp[47:32]};
        a   = $signed({15'b0, adc_t[19:3]}) - (t1 <<< 1);
        m   = a * t2;
        v1t = m >>> 11;
        d   = $signed({16'b0, adc_t[19:4]}) - t1;
        m   = d * d;
        m   = m >>> 12;
        m   = m * t3;
        v2t = m >>> 14;
        tf  = v1t + v2t;
        m   = tf * 32'sd5 + 32'sd128;
        r.temp = m >>> 8;

        x  = tf;
        x  = x - 64'sd128000;
        y  = x * x * widen16(cal_pb[31:16]);
        y  = y + ((x * widen16(cal_pb[15:0])) <<< 17);
        y  = y + (widen16(cal_pa[63:48]) <<< 35);
        x  = ((x * x * widen16(cal_pa[47:32])) >>> 8)
             + ((x * widen16(cal_pa[31:16])) <<< 12);
        dv = ((64'sh0000_8000_0000_0000 + x) * $signed({48'b0, cal_pa[15:0]})) >>> 33;
        if (dv == 0) begin
            r.status = bptc_pkg::ST_FAULT;
            return r;
        end
        p   = 64'sd1048576 - $signed({44'b0, adc_p});
        num = ((p <<< 31) - y) * 64'sd3125;
        p   = div_trunc(num, dv);
        q   = p >>> 13;
        x   = (widen16(cal_p9) * q * q) >>> 25;
        y   = (widen16(cal_pb[63:48]) * p) >>> 19;
        p   = ((p + x + y) >>> 8) + (widen16(cal_pb[47:32]) <<< 4);
        r.press = p[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        bptc_pkg::t_out want;
        if (!i_rst_n) begin
            cal_temp  <= '0;
            cal_pa    <= '0;
            cal_pb    <= '0;
            cal_p9    <= '0;
            o_errors  <= 0;
            o_pending <= 0;
            readings_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    bptc_pkg::REG_TEMP: cal_temp <= i_pwdata[47:0];
                    bptc_pkg::REG_PA:   cal_pa   <= i_pwdata;
                    bptc_pkg::REG_PB:   cal_pb   <= i_pwdata;
                    bptc_pkg::REG_P9:   cal_p9   <= i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                readings_due.push_back(compensate(i_s_tdata[19:0], i_s_tdata[39:20]));
            if (i_m_tvalid && i_m_tready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: result with nothing expected, got temp %h press %h status %0d",
                             $time, i_m_tdata[31:0], i_m_tdata[63:32], i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    want = readings_due.pop_front();
                    if (want.temp !== i_m_tdata[31:0] || want.press !== i_m_tdata[63:32]
                        || want.status !== i_m_tuser) begin
                        $display("%0t: mismatch, expected temp %h press %h status %0d,",
                                 $time, want.temp, want.press, want.status);
                        $display("%0t:   got temp %h press %h status %0d",
                                 $time, i_m_tdata[31:0], i_m_tdata[63:32], i_m_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= readings_due.size();
        end
    end
endmodule

[test/baro_pressure_temp_compensation_tb.sv]
// Testbench top for the barometer compensation block: stimulus, calibration phases and verdict.
module baro_pressure_temp_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int sink_hold = 0;
    // Once set, neither side idles any more.
    bit calm = 1'b0;

    always #5 i_clk = ~i_clk;

    baro_pressure_temp_compensation DUT (.*);

    baro_pressure_temp_compensation_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    // The result side stalls in short random bursts until the calm tail.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            i_m_tready <= 1'b0;
            sink_hold  <= sink_hold - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            i_m_tready <= 1'b0;
            sink_hold  <= $urandom_range(0, 4);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither stream nor the bus moves.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // One bus write: setup cycle, then access cycle. The register takes the
    // data at the edge that ends the access cycle.
    task automatic bus_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Holds the sender back until every expected result has come out, then
    // lets the pipeline drain a little longer before the calibration moves.
    task automatic drain;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
    endtask

    task automatic calibrate(input logic [47:0] tc, input logic [63:0] pa,
                             input logic [63:0] pb, input logic [15:0] p9);
        drain();
        bus_write(bptc_pkg::REG_TEMP, {16'b0, tc});
        bus_write(bptc_pkg::REG_PA, pa);
        bus_write(bptc_pkg::REG_PB, pb);
        bus_write(bptc_pkg::REG_P9, {48'b0, p9});
    endtask

    // Issues one request and returns at the edge where it was taken.
    task automatic push_reading(input logic [19:0] raw_p, input logic [19:0] raw_t);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {raw_t, raw_p};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Mostly uniform raw values, with the reset pattern and the rails mixed in.
    function automatic logic [19:0] pick_raw();
        case ($urandom_range(0, 15))
            0:       return bptc_pkg::RESET_PATTERN;
            1:       return 20'h00000;
            2:       return 20'hFFFFF;
            3:       return 20'(32'h7FFFF + $urandom_range(0, 2));
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic random_readings(input int n);
        repeat (n) push_reading(pick_raw(), pick_raw());
    endtask

    // Typical factory calibration of this class of barometer.
    localparam logic [47:0] TC_TYPICAL = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] PA_TYPICAL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] PB_TYPICAL = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [15:0] P9_TYPICAL = 16'd6000;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration: P1 is zero, so every usable reading is a pressure fault.
        push_reading(20'd415148, 20'd519888);
        push_reading(bptc_pkg::RESET_PATTERN, 20'd519888);
        push_reading(20'd0, 20'hFFFFF);

        calibrate(TC_TYPICAL, PA_TYPICAL, PB_TYPICAL, P9_TYPICAL);
        // Directed: typical readings, the rails and the reset pattern on each side.
        push_reading(20'd415148, 20'd519888);
        push_reading(20'd0, 20'd0);
        push_reading(20'hFFFFF, 20'hFFFFF);
        push_reading(20'd0, 20'hFFFFF);
        push_reading(20'hFFFFF, 20'd0);
        push_reading(bptc_pkg::RESET_PATTERN, 20'd519888);
        push_reading(20'd415148, bptc_pkg::RESET_PATTERN);
        push_reading(bptc_pkg::RESET_PATTERN, bptc_pkg::RESET_PATTERN);
        push_reading(20'h7FFFF, 20'h80001);
        push_reading(20'hAAAAA, 20'h55555);
        push_reading(20'h55555, 20'hAAAAA);
        // Pressure one below full scale leaves a pressure term of one in the numerator.
        push_reading(20'd1048575, 20'd519888);
        random_readings(260);

        calibrate(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
        random_readings(260);

        // All coefficients at their largest patterns.
        calibrate({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF);
        random_readings(120);
        calibrate({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                  {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
        random_readings(120);
        calibrate({16'h8000, 16'h8000, 16'h0001}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                  {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
        random_readings(120);

        calibrate(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
        random_readings(260);

        calibrate(TC_TYPICAL, PA_TYPICAL, PB_TYPICAL, P9_TYPICAL);
        random_readings(300);
        // The tail runs back to back on both sides.
        calm = 1'b1;
        random_readings(250);

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
